FILE: src/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared types and constants for the triangle violation scanner: word
// layouts, operation and form codes, fixed-point thresholds.
// ----------------------------------------------------------------------------
package tvs_pkg;

  // field widths fixed by the word layouts
  localparam int NODE_W  = 6;
  localparam int VALUE_W = 9;
  localparam int FORM_W  = 2;
  localparam int CFG_W   = 7;
  localparam int SUM_W   = 11;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // inequality form codes
  localparam logic [FORM_W-1:0] FORM_IJ_IK = 2'd0;  // ij+ik-jk<=1
  localparam logic [FORM_W-1:0] FORM_IJ_JK = 2'd1;  // ij-ik+jk<=1
  localparam logic [FORM_W-1:0] FORM_IK_JK = 2'd2;  // -ij+ik+jk<=1

  // fixed-point thresholds, 256 = 1.0
  localparam logic [VALUE_W-1:0] EDGE_HIGH_MIN = 9'd231;   // at or above 0.9
  localparam logic [SUM_W-1:0]   SUM_LOW       = 11'd384; // 1.5
  localparam logic [SUM_W-1:0]   SUM_HIGH      = 11'd640; // 2.5

  // node count register reset value
  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd32;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // input word
  typedef struct packed {
    logic               operation;
    logic [NODE_W-1:0]  row_node;
    logic [NODE_W-1:0]  col_node;
    logic [VALUE_W-1:0] edge_value;
  } item_t;

  // result word
  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] pair_row;
    logic [NODE_W-1:0] pair_col;
    logic [NODE_W-1:0] third_node;
    logic [FORM_W-1:0] inequality_form;
    logic              last;
  } result_t;

endpackage

FILE: src/triangle_violation_scanner_core.sv
// Flow: a check leaves the queue, reads edge ij in S_IJ, walks third nodes
//   below the smaller index j in S_EVAL (skipped if ij is high or j is zero)
//   and closes in S_DONE; output stalls can hold S_EVAL and S_DONE.
// Throughput: one edge write per cycle while the engine is idle; a check holds
//   the engine, one third node per cycle unless an output stall holds S_EVAL, reading edges ik and jk for each.
// Reset: clears queue, sequencer and output valid, node count returns to 32;
//   edge store contents stay undefined until written.
// ----------------------------------------------------------------------------
// triangle_violation_scanner_core
// Top level: front classifier, command queue and scan engine with edge store.
// ----------------------------------------------------------------------------
module triangle_violation_scanner_core
  import tvs_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  item_t            in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output result_t          out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  item_t push_data;
  item_t head;

  // accept and classify
  tvs_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // command queue
  tvs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // store and scan
  tvs_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/tvs_front.sv
// ----------------------------------------------------------------------------
// tvs_front
// Holds the node count register, accepts input words and drops those with
// an index out of range or an unordered pair; the rest go to the queue.
// ----------------------------------------------------------------------------
module tvs_front
  import tvs_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  item_t            in_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             q_full,
  output logic             push,
  output item_t            push_data
);

  logic [CFG_W-1:0] node_count;
  logic [CFG_W-1:0] node_limit;
  logic             in_range;

  // node count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  // effective limit is the smaller of register and build size
  assign node_limit = (node_count < CFG_W'(MAX_NODES)) ? node_count : CFG_W'(MAX_NODES);

  // classify the incoming word
  assign in_range = (CFG_W'(in_data.row_node) < node_limit)
                 && (CFG_W'(in_data.col_node) < node_limit)
                 && (in_data.col_node < in_data.row_node);

  assign in_stall  = q_full;
  assign push      = in_valid && !in_stall && in_range;
  assign push_data = in_data;

endmodule

FILE: src/tvs_queue.sv
// ----------------------------------------------------------------------------
// tvs_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tvs_queue
  import tvs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_data,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/tvs_back.sv
// ----------------------------------------------------------------------------
// tvs_back
// Edge store and scan engine: performs writes, walks third nodes for a check
// one per cycle with two store reads unless stalled; drives output register.
// ----------------------------------------------------------------------------
module tvs_back
  import tvs_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   head,
  input  logic    q_empty,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_NODES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_IJ   = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  function automatic logic [AW-1:0] mem_addr(input logic [NW-1:0] a, input logic [NW-1:0] b);
    return AW'(a) * AW'(MAX_NODES) + AW'(b);
  endfunction

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_a;
  logic [VALUE_W-1:0] rd_b;

  logic [1:0]         state, state_next;
  logic [NW-1:0]      row, row_next;
  logic [NW-1:0]      col, col_next;
  logic [NW-1:0]      k, k_next;
  logic [VALUE_W-1:0] vij, vij_next;
  logic               pend_valid, pend_valid_next;
  logic [NW-1:0]      pend_k, pend_k_next;
  logic [FORM_W-1:0]  pend_form, pend_form_next;

  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      addr_a;
  logic [AW-1:0]      addr_b;
  logic               emit;
  result_t            emit_data;
  logic               out_free;

  logic [NW-1:0]      hrow;
  logic [NW-1:0]      hcol;
  logic [NW-1:0]      k_inc;
  logic [SUM_W-1:0]   sum;
  logic               viol;
  logic [FORM_W-1:0]  form;

  assign hrow     = head.row_node[NW-1:0];
  assign hcol     = head.col_node[NW-1:0];
  assign k_inc    = k + NW'(1);
  assign out_free = !out_valid || !out_stall;

  // triangle test on the current third node
  assign sum  = SUM_W'(vij) + SUM_W'(rd_a) + SUM_W'(rd_b);
  assign viol = (sum > SUM_LOW) && (sum < SUM_HIGH);

  always_comb begin
    priority if (rd_b < EDGE_HIGH_MIN) begin
      form = FORM_IJ_IK;
    end else if (rd_a < EDGE_HIGH_MIN) begin
      form = FORM_IJ_JK;
    end else begin
      form = FORM_IK_JK;
    end
  end

  // edge store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mem_addr(hrow, hcol)] <= head.edge_value;
    end
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // scan sequencer
  always_comb begin
    state_next      = state;
    row_next        = row;
    col_next        = col;
    k_next          = k;
    vij_next        = vij;
    pend_valid_next = pend_valid;
    pend_k_next     = pend_k;
    pend_form_next  = pend_form;
    pop             = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    addr_a          = mem_addr(row, k_inc);
    addr_b          = mem_addr(col, k_inc);
    emit            = 1'b0;
    emit_data       = '0;
    emit_data.pair_row = NODE_W'(row);
    emit_data.pair_col = NODE_W'(col);

    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.operation == OP_WRITE) begin
            wr_en = 1'b1;
          end else begin
            row_next   = hrow;
            col_next   = hcol;
            rd_en      = 1'b1;
            addr_a     = mem_addr(hrow, hcol);
            state_next = S_IJ;
          end
        end
      end

      S_IJ: begin
        vij_next        = rd_a;
        pend_valid_next = 1'b0;
        if (rd_a >= EDGE_HIGH_MIN || col == '0) begin
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          k_next     = '0;
          addr_a     = mem_addr(row, '0);
          addr_b     = mem_addr(col, '0);
          state_next = S_EVAL;
        end
      end

      S_EVAL: begin
        // a new hit pushes out the held one, which needs the output free
        if (!(viol && pend_valid && !out_free)) begin
          if (viol) begin
            if (pend_valid) begin
              emit                      = 1'b1;
              emit_data.found           = 1'b1;
              emit_data.third_node      = NODE_W'(pend_k);
              emit_data.inequality_form = pend_form;
              emit_data.last            = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_k_next     = k;
            pend_form_next  = form;
          end
          if (k_inc == col) begin
            state_next = S_DONE;
          end else begin
            k_next = k_inc;
            rd_en  = 1'b1;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
          if (pend_valid) begin
            emit_data.found           = 1'b1;
            emit_data.third_node      = NODE_W'(pend_k);
            emit_data.inequality_form = pend_form;
          end
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
    end
    row       <= row_next;
    col       <= col_next;
    k         <= k_next;
    vij       <= vij_next;
    pend_k    <= pend_k_next;
    pend_form <= pend_form_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
    if (out_free && emit) begin
      out_data <= emit_data;
    end
  end

endmodule

FILE: src/tvs_checker.sv
// ----------------------------------------------------------------------------
// tvs_checker
// Port-level checks on the result channel of the scanner.
// ----------------------------------------------------------------------------
module tvs_checker
  import tvs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_data
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // a no-hit result always closes its check
  a_nohit_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.last)
    else $error("no-hit result without last");

  // a no-hit result carries zero node and form
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found
      |-> out_data.third_node == '0 && out_data.inequality_form == FORM_IJ_IK)
    else $error("no-hit result with nonzero fields");

  // a hit names a third node below the pair
  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found
      |-> out_data.third_node < out_data.pair_col && out_data.pair_col < out_data.pair_row
       && out_data.inequality_form <= FORM_IK_JK)
    else $error("hit result with bad node order or form");

endmodule

bind triangle_violation_scanner_core tvs_checker u_tvs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: sim/triangle_violation_scanner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_violation_scanner_core_tb
// Self-checking bench for the scanner core. Loads edge values, checks pairs
// and compares every result word against a predictor of the triangle scan.
// It walks several node count settings, with random input gaps and output
// stalls.
// ----------------------------------------------------------------------------
module triangle_violation_scanner_core_tb;
  import tvs_pkg::*;

  localparam int NODES       = 32;
  localparam int CYCLE_LIMIT = 600000;

  // predictor of the triangle scan plus the queue of expected result words
  class tri_scoreboard #(int N = 32);
    bit [VALUE_W-1:0] edge_mem [0:N*N-1];
    bit [CFG_W-1:0]   node_count;
    result_t          expected_results[$];

    function new();
      node_count = NODE_COUNT_RESET;
      foreach (edge_mem[a]) edge_mem[a] = '0;
    endfunction

    function void set_node_count(bit [CFG_W-1:0] v);
      node_count = v;
    endfunction

    function int unsigned node_limit();
      return (node_count < N) ? node_count : N;
    endfunction

    function int unsigned waiting();
      return expected_results.size();
    endfunction

    // single word for a pair with no violated triangle
    function result_t clean_result(int unsigned i, int unsigned j);
      result_t r;
      r.found           = 1'b0;
      r.pair_row        = i[NODE_W-1:0];
      r.pair_col        = j[NODE_W-1:0];
      r.third_node      = '0;
      r.inequality_form = FORM_IJ_IK;
      r.last            = 1'b1;
      return r;
    endfunction

    // note an accepted input word: store an edge or queue the scan results
    function void note_input(item_t w);
      int unsigned lim, i, j, v_ij, v_ik, v_jk, sum;
      result_t     held;
      bit          have_hit;
      lim = node_limit();
      i = w.row_node;
      j = w.col_node;
      have_hit = 1'b0;
      if (i >= lim || j >= lim || j >= i) return;
      if (w.operation == OP_WRITE) begin
        edge_mem[i*N + j] = w.edge_value;
        return;
      end
      v_ij = edge_mem[i*N + j];
      if (v_ij >= EDGE_HIGH_MIN) begin
        expected_results.push_back(clean_result(i, j));
        return;
      end
      for (int unsigned k = 0; k < j; k++) begin
        v_ik = edge_mem[i*N + k];
        v_jk = edge_mem[j*N + k];
        sum  = v_ij + v_ik + v_jk;
        if (sum > SUM_LOW && sum < SUM_HIGH) begin
          if (have_hit) expected_results.push_back(held);
          held.found      = 1'b1;
          held.pair_row   = i[NODE_W-1:0];
          held.pair_col   = j[NODE_W-1:0];
          held.third_node = k[NODE_W-1:0];
          held.last       = 1'b0;
          if (v_jk < EDGE_HIGH_MIN)      held.inequality_form = FORM_IJ_IK;
          else if (v_ik < EDGE_HIGH_MIN) held.inequality_form = FORM_IJ_JK;
          else                           held.inequality_form = FORM_IK_JK;
          have_hit = 1'b1;
        end
      end
      if (have_hit) begin
        held.last = 1'b1;
        expected_results.push_back(held);
      end else begin
        expected_results.push_back(clean_result(i, j));
      end
    endfunction

    // compare one result word with the oldest expectation, empty string if ok
    function string check_result(result_t got);
      result_t exp_r;
      string   msg;
      if (expected_results.size() == 0)
        return $sformatf("unexpected result word %h", got);
      exp_r = expected_results.pop_front();
      msg = "";
      if (got.found !== exp_r.found)
        msg = {msg, $sformatf(" found %0d/%0d", got.found, exp_r.found)};
      if (got.pair_row !== exp_r.pair_row)
        msg = {msg, $sformatf(" pair_row %0d/%0d", got.pair_row, exp_r.pair_row)};
      if (got.pair_col !== exp_r.pair_col)
        msg = {msg, $sformatf(" pair_col %0d/%0d", got.pair_col, exp_r.pair_col)};
      if (got.third_node !== exp_r.third_node)
        msg = {msg, $sformatf(" third_node %0d/%0d", got.third_node, exp_r.third_node)};
      if (got.inequality_form !== exp_r.inequality_form)
        msg = {msg, $sformatf(" form %0d/%0d", got.inequality_form,
                              exp_r.inequality_form)};
      if (got.last !== exp_r.last)
        msg = {msg, $sformatf(" last %0d/%0d", got.last, exp_r.last)};
      if (msg != "")
        msg = $sformatf("pair (%0d,%0d) got/expected:%s", exp_r.pair_row,
                        exp_r.pair_col, msg);
      return msg;
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  item_t            in_data;
  logic             out_valid;
  logic             out_stall;
  result_t          out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  tri_scoreboard #(NODES) sb;
  bit                     edge_known [0:NODES*NODES-1];
  int unsigned            issued_items;
  int unsigned            mismatches;
  int unsigned            cycles;
  bit                     quiet;

  triangle_violation_scanner_core #(
    .MAX_NODES(NODES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // result monitor
  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && !out_stall) begin
      msg = sb.check_result(out_data);
      if (msg != "") report_mismatch(msg);
    end
  end

  // output stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic item_t make_item(input logic op, input int row, input int col,
                                      input int val);
    item_t w;
    w.operation  = op;
    w.row_node   = row[NODE_W-1:0];
    w.col_node   = col[NODE_W-1:0];
    w.edge_value = val[VALUE_W-1:0];
    return w;
  endfunction

  // edge values clustered so that many triangles land in the window
  function automatic int rand_value();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(257, 511);
      2, 3:    return $urandom_range(231, 256);
      default: return $urandom_range(110, 230);
    endcase
  endfunction

  // present one input word until accepted, then maybe idle
  task automatic send_word(input item_t w);
    int unsigned lim;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    lim = sb.node_limit();
    if (w.row_node < lim && w.col_node < lim && w.col_node < w.row_node) begin
      issued_items++;
      if (w.operation == OP_WRITE) edge_known[w.row_node*NODES + w.col_node] = 1'b1;
    end
    sb.note_input(w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic put_edge(input int i, input int j, input int val);
    send_word(make_item(OP_WRITE, i, j, val));
  endtask

  // check a pair, first storing any edge the scan would read unwritten
  task automatic check_pair(input int i, input int j);
    for (int k = 0; k < j; k++) begin
      if (!edge_known[i*NODES + k]) put_edge(i, k, rand_value());
      if (!edge_known[j*NODES + k]) put_edge(j, k, rand_value());
    end
    if (!edge_known[i*NODES + j]) put_edge(i, j, rand_value());
    send_word(make_item(OP_CHECK, i, j, $urandom_range(0, 511)));
  endtask

  // drain all expected results, then give queued writes time to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_node_count(input int v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_node_count(v[CFG_W-1:0]);
  endtask

  // random mix of writes, checks and ignored words
  task automatic run_random(input int n_items);
    int unsigned start_count, lim, pick;
    int          i, j, jcap;
    item_t       w;
    start_count = issued_items;
    while (issued_items - start_count < n_items) begin
      lim  = sb.node_limit();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // out of range or unordered word, always ignored
        w = make_item(1'($urandom_range(0, 1)), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom_range(0, 511));
        if (w.row_node < lim && w.col_node < lim && w.col_node < w.row_node)
          w.col_node = w.row_node;
        send_word(w);
      end else if (pick >= 97) begin
        // widest pair, longest walk
        check_pair(lim - 1, lim - 2);
      end else begin
        i    = $urandom_range(1, lim - 1);
        jcap = (i - 1 < 6) ? i - 1 : 6;
        if ($urandom_range(0, 4) != 0) j = $urandom_range(0, jcap);
        else                           j = $urandom_range(0, i - 1);
        if (pick < 55) put_edge(i, j, rand_value());
        else           check_pair(i, j);
      end
    end
  endtask

  // main sequence
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    quiet        = 1'b0;
    cycles       = 0;
    mismatches   = 0;
    issued_items = 0;
    sb = new();
    foreach (edge_known[a]) edge_known[a] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: threshold edges, window bounds, each form, ignored words
    put_edge(1, 0, 231);
    check_pair(1, 0);
    put_edge(1, 0, 230);
    check_pair(1, 0);
    put_edge(1, 0, 100);
    put_edge(2, 0, 100);
    put_edge(2, 1, 184);
    check_pair(2, 1);
    put_edge(2, 1, 185);
    check_pair(2, 1);
    put_edge(1, 0, 240);
    put_edge(2, 1, 100);
    check_pair(2, 1);
    put_edge(1, 0, 231);
    put_edge(2, 0, 231);
    put_edge(2, 1, 177);
    check_pair(2, 1);
    put_edge(2, 1, 178);
    check_pair(2, 1);
    put_edge(1, 0, 100);
    put_edge(2, 0, 300);
    put_edge(2, 1, 0);
    check_pair(2, 1);
    put_edge(2, 0, 511);
    check_pair(2, 1);
    send_word(make_item(OP_WRITE, 63, 62, 0));
    send_word(make_item(OP_CHECK, 63, 63, 511));
    send_word(make_item(OP_CHECK, 3, 5, 0));
    send_word(make_item(OP_WRITE, 4, 4, 256));

    // smallest node count
    write_node_count(2);
    run_random(8);
    // node count past the store size
    write_node_count(64);
    run_random(40);
    write_node_count(17);
    run_random(25);
    write_node_count(63);
    run_random(25);
    // back to the reset value, no idling on either side
    write_node_count(32);
    quiet = 1'b1;
    run_random(20);

    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && sb.waiting() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: triangle_violation_scanner_core.f
src/tvs_pkg.sv
src/tvs_front.sv
src/tvs_queue.sv
src/tvs_back.sv
src/triangle_violation_scanner_core.sv
src/tvs_checker.sv
sim/triangle_violation_scanner_core_tb.sv
